### rtl/core/ljpf_pkg.sv
// shared types, constants and helpers of the lennard-jones pair force block
package ljpf_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int COORD_W       = 32;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int ACC_W         = 48;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_W         = 32;
  localparam int HALF_W        = 24;
  localparam int MAG_W         = 2 * HALF_W;
  localparam int PROD_W        = 2 * MAG_W;
  localparam int R2_W          = 64;
  localparam int FRAC_W        = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EPS   = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     CFG_ONE   = CFG_W'(65536);

  // force and energy scale factors in q.16
  localparam logic [MAG_W-1:0] K_FORCE  = MAG_W'(48) << FRAC_W;
  localparam logic [MAG_W-1:0] K_ENERGY = MAG_W'(4) << FRAC_W;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_CLR, OP_RD, OP_LATI, OP_LATJ, OP_MUL, OP_DIV,
    OP_SKIP, OP_WBJ, OP_WBI, OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    M_SIG2, M_SQX, M_SQY, M_SQZ, M_S2, M_S3, M_S4, M_S6, M_S7,
    M_T, M_C, M_FX, M_FY, M_FZ, M_E1, M_E2
  } mop_t;

  typedef struct packed {
    dp_op_t           op;
    mop_t             mop;
    logic [IDX_W-1:0] addr;
    logic             last;
  } ljpf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic r2_zero;
  } ljpf_sts_t;

  localparam logic signed [ACC_W+1:0] ACC_POS = {3'b000, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W+1:0] ACC_NEG = {3'b111, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
    if (v > ACC_POS) begin
      return ACC_POS[ACC_W-1:0];
    end else if (v < ACC_NEG) begin
      return ACC_NEG[ACC_W-1:0];
    end
    return v[ACC_W-1:0];
  endfunction

endpackage

### rtl/core/ljpf_mul.sv
// shared multiplier, 48x48 unsigned product over four 24x24 partial steps
module ljpf_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ljpf_pkg::MAG_W-1:0]  a_mag,
  input  logic [ljpf_pkg::MAG_W-1:0]  b_mag,
  output logic [ljpf_pkg::PROD_W-1:0] prod,
  output logic                       done
);
  import ljpf_pkg::*;

  logic [MAG_W-1:0]  a_r, b_r;
  logic [PROD_W-1:0] acc_r;
  logic [1:0]        cnt_r;
  logic              run_r, done_r;
  logic [HALF_W-1:0] a_part, b_part;
  logic [MAG_W-1:0]  pp;
  logic [1:0]        sh;
  logic [PROD_W-1:0] pp_sh;

  always_comb begin
    a_part = cnt_r[1] ? a_r[MAG_W-1:HALF_W] : a_r[HALF_W-1:0];
    b_part = cnt_r[0] ? b_r[MAG_W-1:HALF_W] : b_r[HALF_W-1:0];
    pp     = a_part * b_part;
    sh     = {cnt_r[1] & cnt_r[0], cnt_r[1] ^ cnt_r[0]};
    pp_sh  = PROD_W'(pp) << (HALF_W * sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_mag;
      b_r   <= b_mag;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

### rtl/core/ljpf_div.sv
// restoring divider, q16.16 ratio of two 64 bit values, one quotient bit per cycle
module ljpf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ljpf_pkg::R2_W-1:0] num,
  input  logic [ljpf_pkg::R2_W-1:0] den,
  output logic [31:0]              quot,
  output logic                     done
);
  import ljpf_pkg::*;

  logic [R2_W-1:0] rem_r, den_r;
  logic [31:0]     src_r, q_r;
  logic            sat_r, run_r, done_r;
  logic [4:0]      cnt_r;
  logic [R2_W:0]   rem_sh, rem_sub;
  logic            ge;

  always_comb begin
    rem_sh  = {rem_r, src_r[31]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // integer part of 2^16 or more saturates
      sat_r <= {16'd0, num[R2_W-1:FRAC_W]} >= den;
      rem_r <= R2_W'(num[R2_W-1:FRAC_W]);
      src_r <= {num[FRAC_W-1:0], 16'd0};
      den_r <= den;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= ge ? rem_sub[R2_W-1:0] : rem_sh[R2_W-1:0];
      q_r   <= {q_r[30:0], ge};
      src_r <= {src_r[30:0], 1'b0};
    end
  end

  assign quot = sat_r ? 32'hFFFF_FFFF : q_r;
  assign done = done_r;

endmodule

### rtl/core/ljpf_dp.sv
// datapath: coordinate and force memories, config registers, arithmetic and result registers
module ljpf_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ljpf_pkg::ljpf_cmd_t                cmd,
  output ljpf_pkg::ljpf_sts_t                sts,
  input  logic signed [ljpf_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [ljpf_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [ljpf_pkg::COORD_W-1:0] in_pos_z,
  input  logic                               cfg_valid,
  input  logic [ljpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ljpf_pkg::CFG_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic [ljpf_pkg::IDX_W-1:0]         out_particle_index,
  output logic signed [ljpf_pkg::ACC_W-1:0]  out_force_x,
  output logic signed [ljpf_pkg::ACC_W-1:0]  out_force_y,
  output logic signed [ljpf_pkg::ACC_W-1:0]  out_force_z,
  output logic signed [ljpf_pkg::ACC_W-1:0]  out_total_energy,
  output logic                               out_overlap_seen,
  output logic                               out_last_result
);
  import ljpf_pkg::*;

  logic signed [COORD_W-1:0] mem_x [MAX_PARTICLES];
  logic signed [COORD_W-1:0] mem_y [MAX_PARTICLES];
  logic signed [COORD_W-1:0] mem_z [MAX_PARTICLES];
  logic signed [ACC_W-1:0]   fmem_x [MAX_PARTICLES];
  logic signed [ACC_W-1:0]   fmem_y [MAX_PARTICLES];
  logic signed [ACC_W-1:0]   fmem_z [MAX_PARTICLES];

  logic signed [COORD_W-1:0] crd_x_r, crd_y_r, crd_z_r;
  logic signed [ACC_W-1:0]   frd_x_r, frd_y_r, frd_z_r;

  logic [CFG_W-1:0]          sigma_r, eps_r;
  logic signed [COORD_W-1:0] pi_x_r, pi_y_r, pi_z_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r, dz_r;
  logic [R2_W-1:0]           r2_r, sig2_r;
  logic [31:0]               s_r, s2_r, s3_r, s4_r, s6_r, s7_r;
  logic signed [ACC_W-1:0]   c_r, etot_r, energy_r;
  logic signed [ACC_W-1:0]   ai_x_r, ai_y_r, ai_z_r, fj_x_r, fj_y_r, fj_z_r;
  logic                      overlap_r, neg_r;
  mop_t                      mop_r;

  logic                      out_valid_r, out_last_r, out_ovl_r;
  logic [IDX_W-1:0]          out_idx_r;
  logic signed [ACC_W-1:0]   out_fx_r, out_fy_r, out_fz_r, out_e_r;

  logic [MAG_W-1:0]          a_sel, b_sel;
  logic                      neg_sel;
  logic [PROD_W-1:0]         prod;
  logic                      mul_done, div_done;
  logic [31:0]               quot;

  logic [DIFF_W-1:0]         dx_mag, dy_mag, dz_mag;
  logic signed [DIFF_W-1:0]  g_val;
  logic [DIFF_W-1:0]         g_mag;
  logic [ACC_W-1:0]          c_mag, en_mag, et_mag;

  logic [31:0]               upow_res;
  logic [PROD_W-FRAC_W-1:0]  mq_raw, mq_lim, mq_clip;
  logic signed [ACC_W-1:0]   mq_val;
  logic [R2_W:0]             r2_sum;
  logic [R2_W-1:0]           r2_add;
  logic signed [ACC_W+1:0]   e_sum;

  logic                      fw_en;
  logic signed [ACC_W-1:0]   fw_x, fw_y, fw_z;

  function automatic logic [DIFF_W-1:0] dmag(input logic signed [DIFF_W-1:0] d);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  function automatic logic [ACC_W-1:0] amag(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  function automatic logic signed [ACC_W-1:0] add_acc(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b,
                                                       input logic sub);
    logic signed [ACC_W+1:0] ae, be;
    ae = {{2{a[ACC_W-1]}}, a};
    be = {{2{b[ACC_W-1]}}, b};
    return sat_acc(sub ? ae - be : ae + be);
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    dx_mag = dmag(dx_r);
    dy_mag = dmag(dy_r);
    dz_mag = dmag(dz_r);
    g_val  = $signed({1'b0, s7_r}) - $signed({1'b0, s4_r});
    g_mag  = dmag(g_val);
    c_mag  = amag(c_r);
    en_mag = amag(energy_r);
    et_mag = amag(etot_r);
    a_sel   = '0;
    b_sel   = '0;
    neg_sel = 1'b0;
    case (cmd.mop)
      M_SIG2: begin a_sel = MAG_W'(sigma_r); b_sel = MAG_W'(sigma_r); end
      M_SQX:  begin a_sel = MAG_W'(dx_mag); b_sel = MAG_W'(dx_mag); end
      M_SQY:  begin a_sel = MAG_W'(dy_mag); b_sel = MAG_W'(dy_mag); end
      M_SQZ:  begin a_sel = MAG_W'(dz_mag); b_sel = MAG_W'(dz_mag); end
      M_S2:   begin a_sel = MAG_W'(s_r);  b_sel = MAG_W'(s_r);  end
      M_S3:   begin a_sel = MAG_W'(s2_r); b_sel = MAG_W'(s_r);  end
      M_S4:   begin a_sel = MAG_W'(s2_r); b_sel = MAG_W'(s2_r); end
      M_S6:   begin a_sel = MAG_W'(s3_r); b_sel = MAG_W'(s3_r); end
      M_S7:   begin a_sel = MAG_W'(s6_r); b_sel = MAG_W'(s_r);  end
      M_T: begin
        a_sel = MAG_W'(g_mag); b_sel = MAG_W'(eps_r); neg_sel = g_val[DIFF_W-1];
      end
      M_C: begin
        a_sel = c_mag; b_sel = K_FORCE; neg_sel = c_r[ACC_W-1];
      end
      M_FX: begin
        a_sel = c_mag; b_sel = MAG_W'(dx_mag); neg_sel = c_r[ACC_W-1] ^ dx_r[DIFF_W-1];
      end
      M_FY: begin
        a_sel = c_mag; b_sel = MAG_W'(dy_mag); neg_sel = c_r[ACC_W-1] ^ dy_r[DIFF_W-1];
      end
      M_FZ: begin
        a_sel = c_mag; b_sel = MAG_W'(dz_mag); neg_sel = c_r[ACC_W-1] ^ dz_r[DIFF_W-1];
      end
      M_E1: begin
        a_sel = en_mag; b_sel = MAG_W'(eps_r); neg_sel = energy_r[ACC_W-1];
      end
      M_E2: begin
        a_sel = et_mag; b_sel = K_ENERGY; neg_sel = etot_r[ACC_W-1];
      end
      default: begin a_sel = '0; b_sel = '0; end
    endcase
  end

  ljpf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_MUL),
    .a_mag (a_sel),
    .b_mag (b_sel),
    .prod  (prod),
    .done  (mul_done)
  );

  ljpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV),
    .num   (sig2_r),
    .den   (r2_r),
    .quot  (quot),
    .done  (div_done)
  );

  // result shaping
  always_comb begin
    upow_res = (|prod[PROD_W-1:MAG_W]) ? 32'hFFFF_FFFF : prod[MAG_W-1:FRAC_W];
    mq_raw   = prod[PROD_W-1:FRAC_W];
    mq_lim   = neg_r ? ((PROD_W-FRAC_W)'(1) << (ACC_W-1))
                     : (((PROD_W-FRAC_W)'(1) << (ACC_W-1)) - (PROD_W-FRAC_W)'(1));
    mq_clip  = (mq_raw > mq_lim) ? mq_lim : mq_raw;
    mq_val   = neg_r ? -$signed(mq_clip[ACC_W-1:0]) : $signed(mq_clip[ACC_W-1:0]);
    r2_sum   = {1'b0, r2_r} + {1'b0, prod[R2_W-1:0]};
    r2_add   = r2_sum[R2_W] ? '1 : r2_sum[R2_W-1:0];
    e_sum    = {{2{energy_r[ACC_W-1]}}, energy_r} + $signed({18'd0, s6_r})
               - $signed({17'd0, s3_r, 1'b0});
  end

  // force memory write port
  always_comb begin
    fw_en = 1'b0;
    fw_x  = '0;
    fw_y  = '0;
    fw_z  = '0;
    case (cmd.op)
      OP_CLR: fw_en = 1'b1;
      OP_WBJ: begin fw_en = 1'b1; fw_x = fj_x_r; fw_y = fj_y_r; fw_z = fj_z_r; end
      OP_WBI: begin fw_en = 1'b1; fw_x = ai_x_r; fw_y = ai_y_r; fw_z = ai_z_r; end
      default: fw_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mem_x[cmd.addr] <= in_pos_x;
      mem_y[cmd.addr] <= in_pos_y;
      mem_z[cmd.addr] <= in_pos_z;
    end
    crd_x_r <= mem_x[cmd.addr];
    crd_y_r <= mem_y[cmd.addr];
    crd_z_r <= mem_z[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      fmem_x[cmd.addr] <= fw_x;
      fmem_y[cmd.addr] <= fw_y;
      fmem_z[cmd.addr] <= fw_z;
    end
    frd_x_r <= fmem_x[cmd.addr];
    frd_y_r <= fmem_y[cmd.addr];
    frd_z_r <= fmem_z[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r     <= CFG_ONE;
      eps_r       <= CFG_ONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.op == OP_EMIT;
      if (cfg_valid && cfg_index == REG_SIGMA) begin
        sigma_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_EPS) begin
        eps_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLR: begin
        energy_r  <= '0;
        overlap_r <= 1'b0;
      end
      OP_LATI: begin
        pi_x_r <= crd_x_r;
        pi_y_r <= crd_y_r;
        pi_z_r <= crd_z_r;
        ai_x_r <= frd_x_r;
        ai_y_r <= frd_y_r;
        ai_z_r <= frd_z_r;
      end
      OP_LATJ: begin
        dx_r   <= DIFF_W'(pi_x_r) - DIFF_W'(crd_x_r);
        dy_r   <= DIFF_W'(pi_y_r) - DIFF_W'(crd_y_r);
        dz_r   <= DIFF_W'(pi_z_r) - DIFF_W'(crd_z_r);
        fj_x_r <= frd_x_r;
        fj_y_r <= frd_y_r;
        fj_z_r <= frd_z_r;
      end
      OP_MUL: begin
        mop_r <= cmd.mop;
        neg_r <= neg_sel;
      end
      OP_SKIP: overlap_r <= 1'b1;
      default: ;
    endcase
    if (div_done) begin
      s_r <= quot;
    end
    if (mul_done) begin
      case (mop_r)
        M_SIG2: sig2_r <= prod[R2_W-1:0];
        M_SQX:  r2_r   <= prod[R2_W-1:0];
        M_SQY:  r2_r   <= r2_add;
        M_SQZ:  r2_r   <= r2_add;
        M_S2:   s2_r   <= upow_res;
        M_S3:   s3_r   <= upow_res;
        M_S4:   s4_r   <= upow_res;
        M_S6:   s6_r   <= upow_res;
        M_S7: begin
          s7_r     <= upow_res;
          energy_r <= sat_acc(e_sum);
        end
        M_T, M_C: c_r <= mq_val;
        M_FX: begin
          ai_x_r <= add_acc(ai_x_r, mq_val, 1'b1);
          fj_x_r <= add_acc(fj_x_r, mq_val, 1'b0);
        end
        M_FY: begin
          ai_y_r <= add_acc(ai_y_r, mq_val, 1'b1);
          fj_y_r <= add_acc(fj_y_r, mq_val, 1'b0);
        end
        M_FZ: begin
          ai_z_r <= add_acc(ai_z_r, mq_val, 1'b1);
          fj_z_r <= add_acc(fj_z_r, mq_val, 1'b0);
        end
        M_E1, M_E2: etot_r <= mq_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_idx_r  <= cmd.addr;
      out_fx_r   <= frd_x_r;
      out_fy_r   <= frd_y_r;
      out_fz_r   <= frd_z_r;
      out_e_r    <= cmd.last ? etot_r : '0;
      out_ovl_r  <= overlap_r;
      out_last_r <= cmd.last;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.r2_zero  = r2_r == '0;

  assign out_valid          = out_valid_r;
  assign out_particle_index = out_idx_r;
  assign out_force_x        = out_fx_r;
  assign out_force_y        = out_fy_r;
  assign out_force_z        = out_fz_r;
  assign out_total_energy   = out_e_r;
  assign out_overlap_seen   = out_ovl_r;
  assign out_last_result    = out_last_r;

endmodule

### rtl/core/ljpf_ctrl.sv
// controller: load bookkeeping and the pair pass sequencer
module ljpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last_particle,
  output logic                busy,
  output ljpf_pkg::ljpf_cmd_t cmd,
  input  ljpf_pkg::ljpf_sts_t sts
);
  import ljpf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MWAIT, S_CLR, S_RDI, S_LATI, S_RDJ, S_LATJ,
    S_ZCHK, S_DWAIT, S_WBJ, S_WBI, S_ORD, S_OEMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] loaded_r, loaded_nxt, n_r, n_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  mop_t             mop_r, mop_nxt;
  logic             full;

  assign full = loaded_r == CNT_W'(MAX_PARTICLES);

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    mop_nxt    = mop_r;
    cmd.op     = OP_NOP;
    cmd.mop    = mop_r;
    cmd.addr   = '0;
    cmd.last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.addr = loaded_r[IDX_W-1:0];
          if (!full) begin
            cmd.op     = OP_LOAD;
            loaded_nxt = loaded_r + CNT_W'(1);
          end
          if (in_last_particle) begin
            n_nxt      = full ? loaded_r : loaded_r + CNT_W'(1);
            loaded_nxt = '0;
            k_nxt      = '0;
            mop_nxt    = M_SIG2;
            state_nxt  = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.mul_done) begin
          state_nxt = S_MUL;
          case (mop_r)
            M_SIG2: state_nxt = S_CLR;
            M_SQX:  mop_nxt = M_SQY;
            M_SQY:  mop_nxt = M_SQZ;
            M_SQZ:  state_nxt = S_ZCHK;
            M_S2:   mop_nxt = M_S3;
            M_S3:   mop_nxt = M_S4;
            M_S4:   mop_nxt = M_S6;
            M_S6:   mop_nxt = M_S7;
            M_S7:   mop_nxt = M_T;
            M_T:    mop_nxt = M_C;
            M_C:    mop_nxt = M_FX;
            M_FX:   mop_nxt = M_FY;
            M_FY:   mop_nxt = M_FZ;
            M_FZ:   state_nxt = S_WBJ;
            M_E1:   mop_nxt = M_E2;
            M_E2: begin
              k_nxt     = '0;
              state_nxt = S_ORD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.op   = OP_CLR;
        cmd.addr = k_r[IDX_W-1:0];
        k_nxt    = k_r + CNT_W'(1);
        if (k_r + CNT_W'(1) == n_r) begin
          k_nxt = '0;
          i_nxt = '0;
          if (n_r < CNT_W'(2)) begin
            mop_nxt   = M_E1;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_RDI;
          end
        end
      end
      S_RDI: begin
        cmd.op    = OP_RD;
        cmd.addr  = i_r;
        state_nxt = S_LATI;
      end
      S_LATI: begin
        cmd.op    = OP_LATI;
        j_nxt     = CNT_W'(i_r) + CNT_W'(1);
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        cmd.op    = OP_RD;
        cmd.addr  = j_r[IDX_W-1:0];
        state_nxt = S_LATJ;
      end
      S_LATJ: begin
        cmd.op    = OP_LATJ;
        mop_nxt   = M_SQX;
        state_nxt = S_MUL;
      end
      S_ZCHK: begin
        if (sts.r2_zero) begin
          cmd.op    = OP_SKIP;
          state_nxt = S_WBJ;
        end else begin
          cmd.op    = OP_DIV;
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          mop_nxt   = M_S2;
          state_nxt = S_MUL;
        end
      end
      S_WBJ: begin
        cmd.op   = OP_WBJ;
        cmd.addr = j_r[IDX_W-1:0];
        j_nxt    = j_r + CNT_W'(1);
        state_nxt = (j_r + CNT_W'(1) == n_r) ? S_WBI : S_RDJ;
      end
      S_WBI: begin
        cmd.op   = OP_WBI;
        cmd.addr = i_r;
        if (CNT_W'(i_r) + CNT_W'(2) == n_r) begin
          mop_nxt   = M_E1;
          state_nxt = S_MUL;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_RDI;
        end
      end
      S_ORD: begin
        cmd.op    = OP_RD;
        cmd.addr  = k_r[IDX_W-1:0];
        state_nxt = S_OEMIT;
      end
      S_OEMIT: begin
        cmd.op   = OP_EMIT;
        cmd.addr = k_r[IDX_W-1:0];
        cmd.last = k_r + CNT_W'(1) == n_r;
        k_nxt    = k_r + CNT_W'(1);
        state_nxt = cmd.last ? S_IDLE : S_ORD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      loaded_r <= '0;
      n_r      <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      mop_r    <= M_SIG2;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      n_r      <= n_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      mop_r    <= mop_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

### rtl/core/lennard_jones_pair_forces_top.sv
// top level of the lennard-jones pairwise force and energy block
//
//  channel   handshake                 payload
//  -------   -----------------------   ----------------------------------------------
//  request   start / busy              in_pos_x/y/z (q16.16), in_last_particle
//  result    out_valid (strobe)        out_particle_index, out_force_x/y/z (q32.16),
//                                      out_total_energy, out_overlap_seen, out_last_result
//  config    cfg_valid / cfg_ready     cfg_index (0 sigma, 1 epsilon), cfg_data
//
// a request without the last flag is stored, unless the memory is full, and busy stays low
// a last request starts a pass: sigma squared, a clear of the n force entries, then each pair
//   (13 products on the shared multiplier and one divide; a pair with r2 = 0 stops after its squares),
//   energy scaling on the multiplier, and the result walk
// results come as single-cycle strobes; the receiver cannot stall them
// reset is synchronous and active low; sigma and epsilon return to 1.0
// config is always ready; coordinate and force memories have no reset
module lennard_jones_pair_forces_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ljpf_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [ljpf_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [ljpf_pkg::COORD_W-1:0] in_pos_z,
  input  logic                               in_last_particle,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ljpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ljpf_pkg::CFG_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic [ljpf_pkg::IDX_W-1:0]         out_particle_index,
  output logic signed [ljpf_pkg::ACC_W-1:0]  out_force_x,
  output logic signed [ljpf_pkg::ACC_W-1:0]  out_force_y,
  output logic signed [ljpf_pkg::ACC_W-1:0]  out_force_z,
  output logic signed [ljpf_pkg::ACC_W-1:0]  out_total_energy,
  output logic                               out_overlap_seen,
  output logic                               out_last_result
);
  import ljpf_pkg::*;

  ljpf_cmd_t cmd;
  ljpf_sts_t sts;

  // config registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: loading, pair loop, scaling, result walk
  ljpf_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_last_particle (in_last_particle),
    .busy             (busy),
    .cmd              (cmd),
    .sts              (sts)
  );

  // storage and arithmetic
  ljpf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .cfg_valid          (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_particle_index (out_particle_index),
    .out_force_x        (out_force_x),
    .out_force_y        (out_force_y),
    .out_force_z        (out_force_z),
    .out_total_energy   (out_total_energy),
    .out_overlap_seen   (out_overlap_seen),
    .out_last_result    (out_last_result)
  );

endmodule

### rtl/core/ljpf_checker.sv
// port-level checks of the top level and their binding
module ljpf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               in_last_particle,
  input logic                               out_valid,
  input logic                               out_last_result,
  input logic [ljpf_pkg::IDX_W-1:0]         out_particle_index,
  input logic signed [ljpf_pkg::ACC_W-1:0]  out_total_energy
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on back to back cycles");

  a_pass_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_particle |=> busy)
    else $error("last request did not start a pass");

  a_energy_final_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> out_total_energy == '0)
    else $error("energy on a non-final result");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> ##2
      (out_valid && out_particle_index == $past(out_particle_index, 2) + 1'b1))
    else $error("result index did not advance");

endmodule

bind lennard_jones_pair_forces_top ljpf_checker u_ljpf_checker (.*);

### test/tb_lennard_jones_pair_forces_top.sv
`timescale 1ns / 100ps
// testbench of the lennard-jones pair force block: fixed-point force predictor and random particle sets

module tb_lennard_jones_pair_forces_top;
  import ljpf_pkg::*;

  // run limit in clock cycles
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam longint SAT_POS = 64'sd140737488355327;
  localparam longint SAT_NEG = -64'sd140737488355328;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [ACC_W-1:0] fx;
    logic [ACC_W-1:0] fy;
    logic [ACC_W-1:0] fz;
    logic [ACC_W-1:0] energy;
    logic             overlap;
    logic             last;
  } force_sum_t;

  // predicts the per-particle force sums of each pass and checks them in order
  class force_scoreboard;
    longint     px[MAX_PARTICLES];
    longint     py[MAX_PARTICLES];
    longint     pz[MAX_PARTICLES];
    int         loaded;
    longint     sigma;
    longint     eps;
    force_sum_t sums_due[$];
    int         mismatches;

    function new();
      sigma = 65536;
      eps = 65536;
      loaded = 0;
      mismatches = 0;
    endfunction

    function void write_reg(int idx, logic [CFG_W-1:0] val);
      if (idx == REG_SIGMA) begin
        sigma = longint'(val);
      end else if (idx == REG_EPS) begin
        eps = longint'(val);
      end
    endfunction

    function longint sat48(longint v);
      if (v > SAT_POS) return SAT_POS;
      if (v < SAT_NEG) return SAT_NEG;
      return v;
    endfunction

    // q.16 signed product, truncated toward zero, saturated to 48 bits
    function longint mul_q16(longint v, longint k);
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] p;
      logic [127:0] lim;
      bit           neg;
      neg = (v < 0) != (k < 0);
      a = (v < 0) ? 128'(-v) : 128'(v);
      b = (k < 0) ? 128'(-k) : 128'(k);
      if (a == 0 || b == 0) return 0;
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      p = (a * b) >> 16;
      if (p > lim) p = lim;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function logic [63:0] pow_q16(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = (128'(a) * 128'(b)) >> 16;
      return (p > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : p[63:0];
    endfunction

    function logic [63:0] square_mag(longint d);
      logic [63:0] m;
      m = (d < 0) ? 64'(-d) : 64'(d);
      return m * m;
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[64] ? 64'hFFFF_FFFF_FFFF_FFFF : t[63:0];
    endfunction

    // sigma^2 / r2 in unsigned q16.16, saturated
    function logic [63:0] sigma_ratio(logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      q = {num, 16'b0} / 128'(den);
      return (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
    endfunction

    function void note_request(longint x, longint y, longint z, bit last);
      longint      fx[MAX_PARTICLES];
      longint      fy[MAX_PARTICLES];
      longint      fz[MAX_PARTICLES];
      longint      energy_sum, total, dx, dy, dz, c, f;
      logic [63:0] sig2, r2, s, s2, s3, s4, s6, s7;
      bit          overlap;
      int          n;
      force_sum_t  r;
      if (loaded < MAX_PARTICLES) begin
        px[loaded] = x;
        py[loaded] = y;
        pz[loaded] = z;
        loaded++;
      end
      if (!last) return;
      n = loaded;
      loaded = 0;
      energy_sum = 0;
      overlap = 0;
      sig2 = 64'(sigma) * 64'(sigma);
      for (int i = 0; i < n; i++) begin
        fx[i] = 0;
        fy[i] = 0;
        fz[i] = 0;
      end
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          dx = px[i] - px[j];
          dy = py[i] - py[j];
          dz = pz[i] - pz[j];
          r2 = add_sat(add_sat(square_mag(dx), square_mag(dy)), square_mag(dz));
          if (r2 == 0) begin
            overlap = 1;
            continue;
          end
          s = sigma_ratio(sig2, r2);
          s2 = pow_q16(s, s);
          s3 = pow_q16(s2, s);
          s4 = pow_q16(s2, s2);
          s6 = pow_q16(s3, s3);
          s7 = pow_q16(s6, s);
          energy_sum = sat48(energy_sum + longint'(s6) - 2 * longint'(s3));
          c = mul_q16(mul_q16(longint'(s7) - longint'(s4), eps), longint'(48) << 16);
          f = mul_q16(c, dx);
          fx[i] = sat48(fx[i] - f);
          fx[j] = sat48(fx[j] + f);
          f = mul_q16(c, dy);
          fy[i] = sat48(fy[i] - f);
          fy[j] = sat48(fy[j] + f);
          f = mul_q16(c, dz);
          fz[i] = sat48(fz[i] - f);
          fz[j] = sat48(fz[j] + f);
        end
      end
      total = mul_q16(mul_q16(energy_sum, eps), longint'(4) << 16);
      for (int i = 0; i < n; i++) begin
        r.idx = IDX_W'(i);
        r.fx = fx[i][ACC_W-1:0];
        r.fy = fy[i][ACC_W-1:0];
        r.fz = fz[i][ACC_W-1:0];
        r.last = (i + 1 == n);
        r.energy = r.last ? total[ACC_W-1:0] : '0;
        r.overlap = overlap;
        sums_due.push_back(r);
      end
    endfunction

    function void check_result(force_sum_t got);
      force_sum_t want;
      if (sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %0d fx %h", got.idx, got.fx);
        return;
      end
      want = sums_due.pop_front();
      if (got.idx !== want.idx || got.fx !== want.fx || got.fy !== want.fy ||
          got.fz !== want.fz || got.energy !== want.energy ||
          got.overlap !== want.overlap || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: idx %0d f %h %h %h e %h ov %b last %b", want.idx,
                   want.fx, want.fy, want.fz, want.energy, want.overlap, want.last);
          $display("         got: idx %0d f %h %h %h e %h ov %b last %b", got.idx,
                   got.fx, got.fy, got.fz, got.energy, got.overlap, got.last);
        end
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic signed [COORD_W-1:0]   in_pos_x;
  logic signed [COORD_W-1:0]   in_pos_y;
  logic signed [COORD_W-1:0]   in_pos_z;
  logic                        in_last_particle;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;
  logic                        out_valid;
  logic [IDX_W-1:0]            out_particle_index;
  logic signed [ACC_W-1:0]     out_force_x;
  logic signed [ACC_W-1:0]     out_force_y;
  logic signed [ACC_W-1:0]     out_force_z;
  logic signed [ACC_W-1:0]     out_total_energy;
  logic                        out_overlap_seen;
  logic                        out_last_result;

  force_scoreboard board = new();
  int              sender_idle_pct;
  int              requests_sent;
  longint          cycle_count;

  lennard_jones_pair_forces_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_last_particle   (in_last_particle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_particle_index (out_particle_index),
    .out_force_x        (out_force_x),
    .out_force_y        (out_force_y),
    .out_force_z        (out_force_z),
    .out_total_energy   (out_total_energy),
    .out_overlap_seen   (out_overlap_seen),
    .out_last_result    (out_last_result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // every strobe is one result; the receiver has no way to push back
  always @(posedge clk) begin
    force_sum_t got;
    if (rst_n && out_valid) begin
      got.idx = out_particle_index;
      got.fx = out_force_x;
      got.fy = out_force_y;
      got.fz = out_force_z;
      got.energy = out_total_energy;
      got.overlap = out_overlap_seen;
      got.last = out_last_result;
      board.check_result(got);
    end
  end

  // one particle request; start stays high into the next request when no gap is drawn
  task automatic send_request(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, bit last);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_last_particle <= last;
    do @(posedge clk); while (busy);
    board.note_request(x, y, z, last);
    requests_sent++;
  endtask

  // drain all pending results and let the pass wind down before touching registers
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (board.sums_due.size() != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one particle set: mostly a tight cluster, sometimes full-range, with duplicates mixed in
  task automatic run_set(int n);
    logic signed [31:0] x, y, z;
    int                 cx, cy, cz;
    bit                 wide;
    wide = ($urandom_range(99) < 15);
    cx = int'($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
    cy = int'($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
    cz = int'($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
    x = 0;
    y = 0;
    z = 0;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(99) >= 10) begin
        if (wide) begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end else begin
          x = cx + int'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
          y = cy + int'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
          z = cz + int'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        end
      end
      send_request(x, y, z, i == n - 1);
    end
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    start = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_last_particle = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    requests_sent = 0;
    sender_idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at unit sigma and epsilon
    write_reg(REG_SIGMA, CFG_ONE);
    write_reg(REG_EPS, CFG_ONE);
    // single particle, zero force and energy
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    // coordinate extremes, r2 saturates
    send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    // coincident pair skipped and flagged
    send_request(0, 0, 0, 1'b0);
    send_request(0, 0, 0, 1'b0);
    send_request(32'sh0001_0000, 0, 0, 1'b1);
    // very close pair drives the force into saturation
    send_request(0, 0, 0, 1'b0);
    send_request(32'sh0000_199A, -32'sh0000_0CCD, 32'sh0000_03E8, 1'b1);
    // near the well minimum
    send_request(0, 0, 0, 1'b0);
    send_request(0, 32'sh0001_0000, 0, 1'b0);
    send_request(0, 0, -32'sh0001_199A, 1'b1);
    // alternating bit patterns
    send_request(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0);
    send_request(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b1);

    // three idling phases, three register settings each
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 65 : 0;
      for (int chunk = 0; chunk < 3; chunk++) begin
        settle();
        k = ph * 3 + chunk;
        case (k)
          1: begin
            write_reg(REG_SIGMA, '0);
            write_reg(REG_EPS, 32'hFFFF_FFFF);
          end
          2: begin
            write_reg(REG_SIGMA, 32'hFFFF_FFFF);
            write_reg(REG_EPS, CFG_ONE);
          end
          4: begin
            write_reg(REG_SIGMA, CFG_ONE);
            write_reg(REG_EPS, '0);
          end
          7: begin
            // register index past the list is ignored
            write_reg(CFG_IDX_W'($urandom_range(255, 2)), $urandom);
            write_reg(REG_SIGMA, $urandom_range(98304, 32768));
          end
          default: begin
            write_reg(REG_SIGMA, $urandom_range(98304, 32768));
            write_reg(REG_EPS, $urandom_range(32'h0010_0000));
          end
        endcase
        while (requests_sent < 13 + 26 * (k + 1))
          run_set(($urandom_range(99) < 10) ? 1 : $urandom_range(8, 2));
      end
    end

    // full store, then an overfull set whose extra particles are dropped
    settle();
    write_reg(REG_SIGMA, CFG_ONE);
    write_reg(REG_EPS, $urandom_range(32'h0002_0000));
    run_set(MAX_PARTICLES);
    run_set(MAX_PARTICLES + 3);

    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (board.sums_due.size() != 0);
    repeat (50) @(posedge clk);
    if (board.mismatches == 0 && board.sums_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
